// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, a, b, msg) \
  `ASSERT_CLK(label, (a) |-> (b), msg)

`endif

// ===== design/fsa_pkg.sv =====
// Types and constants of the free segment allocator.
`default_nettype none
package fsa_pkg;
  localparam int SEG_SLOTS = 64;
  localparam int SLOT_W    = $clog2(SEG_SLOTS);
  localparam int CNT_W     = $clog2(SEG_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SEG_SLOTS);

  localparam logic [16:0] HEAP_BYTES = 17'd65536;
  localparam logic [15:0] GROW_BYTES = 16'd4096;
  localparam logic [15:0] HDR_BYTES  = 16'd16;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic REG_FIT   = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] size;
  } seg_t;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_INFO  = 2'd2,
    REQ_BAD   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_INVALID    = 2'd1,
    STAT_NO_SPACE   = 2'd2,
    STAT_TABLE_FULL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ASCAN,
    S_AGROW,
    S_ATAKE,
    S_FSCAN,
    S_FDECIDE,
    S_SHDN,
    S_SHUP,
    S_ISCAN
  } state_t;
endpackage
`default_nettype wire

// ===== design/free_segment_allocator.sv =====
// Free segment allocator: top level with sequencer over the segment table RAM.
// An alloc scans the free segments (at most 64), may grow the heap and rescan, and may
//   then remove a used-up segment; info and free scan the same table.
// One request at a time; the table RAM's single read port sets the pace, one
//   entry per cycle for scans and shifts.
// Reset (synchronous) empties the table, zeroes heap size and both registers.
`default_nettype none
module free_segment_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] req_size,
  input  wire logic [15:0] req_addr,
  output logic             done,
  output logic [1:0]       status,
  output logic [15:0]      grant_addr,
  output logic [15:0]      grant_size,
  output logic [16:0]      free_total,
  output logic [6:0]       chunk_count,
  output logic [16:0]      largest_free,
  output logic [16:0]      smallest_free,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [16:0] cfg_data
);
  import fsa_pkg::*;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [16:0] heap_used, heap_used_next;
  logic [1:0]  fit_pol, fit_pol_next;
  logic [16:0] heap_lim, heap_lim_next;
  logic [1:0]  rq_type, rq_type_next;
  logic [15:0] rq_size, rq_size_next;
  logic [15:0] rq_addr, rq_addr_next;
  logic [CNT_W-1:0] rd_ptr, rd_ptr_next;
  logic rv, rv_next;
  logic [SLOT_W-1:0] ridx, ridx_next;
  logic hit, hit_next;
  logic grown, grown_next;
  logic [SLOT_W-1:0] pick_idx, pick_idx_next;
  seg_t pick_seg, pick_seg_next;
  seg_t tail_seg, tail_seg_next;
  seg_t prev_seg, prev_seg_next;
  logic [CNT_W-1:0] pidx, pidx_next;
  logic [CNT_W-1:0] sh_end, sh_end_next;
  logic done_next;
  logic [1:0]  status_next;
  logic [15:0] grant_addr_next, grant_size_next;
  logic [16:0] free_total_next, largest_free_next, smallest_free_next;
  logic [6:0]  chunk_count_next;

  logic mem_re, mem_we;
  logic [SLOT_W-1:0] mem_raddr, mem_waddr;
  seg_t mem_wdata;
  logic [$bits(seg_t)-1:0] mem_rdata;
  seg_t rd_seg;

  logic [15:0] fstart;
  logic [16:0] fend;
  logic [16:0] lim;
  logic [17:0] grow_sum, tail_end, prev_end;
  logic tail_merge, split, fits, scan_done, take;
  logic has_prev, ovl, mprev, mnext;
  logic [CNT_W-1:0] rd_prev, pidx_dec;

  fsa_seg_ram #(.DEPTH(SEG_SLOTS), .WIDTH($bits(seg_t))) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rd_seg     = mem_rdata;
  assign busy       = (state != S_IDLE);
  assign fstart     = rq_addr - HDR_BYTES;
  assign fend       = {1'b0, rq_addr} + {1'b0, rq_size};
  assign lim        = (heap_lim == 17'd0 || heap_lim > HEAP_BYTES) ? HEAP_BYTES : heap_lim;
  assign grow_sum   = {1'b0, heap_used} + {2'b0, GROW_BYTES};
  assign tail_end   = {2'b0, tail_seg.start} + {2'b0, HDR_BYTES} + {2'b0, tail_seg.size};
  assign tail_merge = (cnt != '0) && (tail_end == {1'b0, heap_used});
  assign prev_end   = {2'b0, prev_seg.start} + {2'b0, HDR_BYTES} + {2'b0, prev_seg.size};
  assign split      = {1'b0, pick_seg.size} > ({1'b0, rq_size} + {1'b0, HDR_BYTES});
  assign fits       = rd_seg.size >= rq_size;
  assign scan_done  = (rd_ptr >= cnt) && !rv;
  assign rd_prev    = rd_ptr - 1'b1;
  assign pidx_dec   = pidx - 1'b1;
  assign has_prev   = (pidx != '0);
  assign ovl        = (has_prev && prev_end > {2'b0, fstart}) ||
                      (hit && fend > {1'b0, pick_seg.start});
  assign mprev      = has_prev && (prev_end == {2'b0, fstart});
  assign mnext      = hit && ({1'b0, pick_seg.start} == fend);

  always_comb begin
    case (fit_pol)
      FIT_BEST:  take = fits && (!hit || rd_seg.size < pick_seg.size);
      FIT_WORST: take = fits && (!hit || rd_seg.size > pick_seg.size);
      default:   take = fits && !hit;
    endcase
  end

  always_comb begin
    state_next         = state;
    cnt_next           = cnt;
    heap_used_next     = heap_used;
    fit_pol_next       = fit_pol;
    heap_lim_next      = heap_lim;
    rq_type_next       = rq_type;
    rq_size_next       = rq_size;
    rq_addr_next       = rq_addr;
    rd_ptr_next        = rd_ptr;
    hit_next           = hit;
    grown_next         = grown;
    pick_idx_next      = pick_idx;
    pick_seg_next      = pick_seg;
    tail_seg_next      = tail_seg;
    prev_seg_next      = prev_seg;
    pidx_next          = pidx;
    sh_end_next        = sh_end;
    done_next          = 1'b0;
    status_next        = status;
    grant_addr_next    = grant_addr;
    grant_size_next    = grant_size;
    free_total_next    = free_total;
    chunk_count_next   = chunk_count;
    largest_free_next  = largest_free;
    smallest_free_next = smallest_free;
    mem_re             = 1'b0;
    mem_raddr          = rd_ptr[SLOT_W-1:0];
    mem_we             = 1'b0;
    mem_waddr          = ridx;
    mem_wdata          = rd_seg;

    unique case (state)
      S_IDLE: begin
        if (cfg_we) begin
          unique case (cfg_addr)
            REG_FIT:   fit_pol_next = cfg_data[1:0];
            REG_LIMIT: heap_lim_next = cfg_data;
          endcase
          cnt_next       = '0;
          heap_used_next = '0;
        end
        if (start) begin
          rq_type_next       = req_type;
          rq_size_next       = req_size;
          rq_addr_next       = req_addr;
          status_next        = STAT_OK;
          grant_addr_next    = '0;
          grant_size_next    = '0;
          free_total_next    = '0;
          chunk_count_next   = '0;
          largest_free_next  = '0;
          smallest_free_next = '0;
          state_next         = S_CHECK;
        end
      end

      S_CHECK: begin
        rd_ptr_next = '0;
        hit_next    = 1'b0;
        grown_next  = 1'b0;
        unique case (rq_type)
          REQ_ALLOC: begin
            if (rq_size == '0) begin
              status_next = STAT_INVALID;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              state_next = S_ASCAN;
            end
          end
          REQ_FREE: begin
            if (rq_addr == '0) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else if (rq_size == '0 || rq_addr < HDR_BYTES || fend > heap_used) begin
              status_next = STAT_INVALID;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              state_next = S_FSCAN;
            end
          end
          REQ_INFO: state_next = S_ISCAN;
          default: begin
            status_next = STAT_INVALID;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end
        endcase
      end

      S_ASCAN: begin
        if (rd_ptr < cnt) begin
          mem_re      = 1'b1;
          rd_ptr_next = rd_ptr + 1'b1;
        end
        if (rv) begin
          tail_seg_next = rd_seg;
          if (take) begin
            hit_next      = 1'b1;
            pick_idx_next = ridx;
            pick_seg_next = rd_seg;
          end
        end
        if (scan_done) begin
          if (hit) begin
            state_next = S_ATAKE;
          end else if (grown) begin
            status_next = STAT_NO_SPACE;
            done_next   = 1'b1;
            state_next  = S_IDLE;
          end else begin
            state_next = S_AGROW;
          end
        end
      end

      S_AGROW: begin
        if (grow_sum > {1'b0, lim}) begin
          status_next = STAT_NO_SPACE;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else if (!tail_merge && cnt >= SLOTS_CNT) begin
          status_next = STAT_TABLE_FULL;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          mem_we = 1'b1;
          if (tail_merge) begin
            mem_waddr = cnt[SLOT_W-1:0] - 1'b1;
            mem_wdata = '{start: tail_seg.start, size: tail_seg.size + GROW_BYTES};
          end else begin
            mem_waddr = cnt[SLOT_W-1:0];
            mem_wdata = '{start: heap_used[15:0], size: GROW_BYTES - HDR_BYTES};
            cnt_next  = cnt + 1'b1;
          end
          heap_used_next = grow_sum[16:0];
          grown_next     = 1'b1;
          rd_ptr_next    = '0;
          hit_next       = 1'b0;
          state_next     = S_ASCAN;
        end
      end

      S_ATAKE: begin
        grant_addr_next = pick_seg.start + HDR_BYTES;
        if (split) begin
          mem_we          = 1'b1;
          mem_waddr       = pick_idx;
          mem_wdata       = '{start: pick_seg.start + HDR_BYTES + rq_size,
                              size:  pick_seg.size - rq_size - HDR_BYTES};
          grant_size_next = rq_size;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end else begin
          grant_size_next = pick_seg.size;
          rd_ptr_next     = {1'b0, pick_idx} + 1'b1;
          sh_end_next     = cnt;
          state_next      = S_SHDN;
        end
      end

      S_FSCAN: begin
        if (rd_ptr < cnt && !hit) begin
          mem_re      = 1'b1;
          rd_ptr_next = rd_ptr + 1'b1;
        end
        if (rv && !hit) begin
          if (rd_seg.start > fstart) begin
            hit_next      = 1'b1;
            pidx_next     = {1'b0, ridx};
            pick_seg_next = rd_seg;
          end else begin
            prev_seg_next = rd_seg;
          end
        end
        if (hit) begin
          state_next = S_FDECIDE;
        end else if (scan_done) begin
          pidx_next  = cnt;
          state_next = S_FDECIDE;
        end
      end

      S_FDECIDE: begin
        if (ovl) begin
          status_next = STAT_INVALID;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else if (mprev && mnext) begin
          mem_we      = 1'b1;
          mem_waddr   = pidx_dec[SLOT_W-1:0];
          mem_wdata   = '{start: prev_seg.start,
                          size: prev_seg.size + HDR_BYTES + rq_size + HDR_BYTES +
                                pick_seg.size};
          rd_ptr_next = pidx + 1'b1;
          sh_end_next = cnt;
          state_next  = S_SHDN;
        end else if (mprev) begin
          mem_we     = 1'b1;
          mem_waddr  = pidx_dec[SLOT_W-1:0];
          mem_wdata  = '{start: prev_seg.start, size: prev_seg.size + HDR_BYTES + rq_size};
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (mnext) begin
          mem_we     = 1'b1;
          mem_waddr  = pidx[SLOT_W-1:0];
          mem_wdata  = '{start: fstart, size: pick_seg.size + HDR_BYTES + rq_size};
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (cnt >= SLOTS_CNT) begin
          status_next = STAT_TABLE_FULL;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          rd_ptr_next = cnt;
          sh_end_next = pidx;
          state_next  = S_SHUP;
        end
      end

      S_SHDN: begin
        if (rd_ptr < sh_end) begin
          mem_re      = 1'b1;
          rd_ptr_next = rd_ptr + 1'b1;
        end
        if (rv) begin
          mem_we    = 1'b1;
          mem_waddr = ridx - 1'b1;
        end
        if (rd_ptr >= sh_end && !rv) begin
          cnt_next   = cnt - 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_SHUP: begin
        if (rd_ptr > sh_end) begin
          mem_re      = 1'b1;
          mem_raddr   = rd_prev[SLOT_W-1:0];
          rd_ptr_next = rd_prev;
        end
        if (rv) begin
          mem_we    = 1'b1;
          mem_waddr = ridx + 1'b1;
        end
        if (rd_ptr <= sh_end && !rv) begin
          mem_we     = 1'b1;
          mem_waddr  = pidx[SLOT_W-1:0];
          mem_wdata  = '{start: fstart, size: rq_size};
          cnt_next   = cnt + 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_ISCAN: begin
        if (rd_ptr < cnt) begin
          mem_re      = 1'b1;
          rd_ptr_next = rd_ptr + 1'b1;
        end
        if (rv) begin
          free_total_next  = free_total + {1'b0, rd_seg.size};
          chunk_count_next = chunk_count + 1'b1;
          if ({1'b0, rd_seg.size} > largest_free) begin
            largest_free_next = {1'b0, rd_seg.size};
          end
          if (smallest_free == '0 || {1'b0, rd_seg.size} < smallest_free) begin
            smallest_free_next = {1'b0, rd_seg.size};
          end
        end
        if (scan_done) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      heap_used <= '0;
      fit_pol   <= FIT_FIRST;
      heap_lim  <= '0;
      rv        <= 1'b0;
      hit       <= 1'b0;
      grown     <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      heap_used <= heap_used_next;
      fit_pol   <= fit_pol_next;
      heap_lim  <= heap_lim_next;
      rv        <= rv_next;
      hit       <= hit_next;
      grown     <= grown_next;
      done      <= done_next;
    end
  end

  assign rv_next   = mem_re;
  assign ridx_next = mem_raddr;

  always_ff @(posedge clk) begin
    rq_type       <= rq_type_next;
    rq_size       <= rq_size_next;
    rq_addr       <= rq_addr_next;
    rd_ptr        <= rd_ptr_next;
    ridx          <= ridx_next;
    pick_idx      <= pick_idx_next;
    pick_seg      <= pick_seg_next;
    tail_seg      <= tail_seg_next;
    prev_seg      <= prev_seg_next;
    pidx          <= pidx_next;
    sh_end        <= sh_end_next;
    status        <= status_next;
    grant_addr    <= grant_addr_next;
    grant_size    <= grant_size_next;
    free_total    <= free_total_next;
    chunk_count   <= chunk_count_next;
    largest_free  <= largest_free_next;
    smallest_free <= smallest_free_next;
  end
endmodule
`default_nettype wire

// ===== design/fsa_seg_ram.sv =====
// Single-port-write, registered-read RAM for the segment table.
`default_nettype none
module fsa_seg_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== design/fsa_checker.sv =====
// Port-level checker for the free segment allocator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module fsa_port_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [1:0]  status,
  input wire logic [15:0] grant_addr,
  input wire logic [15:0] grant_size,
  input wire logic [6:0]  chunk_count,
  input wire logic [16:0] largest_free,
  input wire logic [16:0] smallest_free
);
  import fsa_pkg::*;

  `ASSERT_IMPLIES(a_done_idle, done, !busy, "result strobe while busy")
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted transaction not busy")
  `ASSERT_CLK(a_done_single, done |=> !done, "result strobe repeated")
  `ASSERT_IMPLIES(a_fail_nogrant, done && status != STAT_OK,
                  grant_addr == '0 && grant_size == '0, "grant on failed transaction")
  `ASSERT_IMPLIES(a_empty_stats, done && chunk_count == '0,
                  largest_free == '0 && smallest_free == '0, "extremes with no segments")
endmodule

bind free_segment_allocator fsa_port_checker u_fsa_checker (.*);
`default_nettype wire
